FILE: src/pss_pkg.sv
// shared widths, command codes and status codes of the positional stack store
`default_nettype none

package pss_pkg;

	// default sizing of the store
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the ports
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

FILE: src/positional_stack_store_top.sv
// bounded stack with positional insert, delete and search over one synchronous memory
//
// channel | direction | handshake           | payload
// in      | into      | in_valid / in_stall | cmd, item_value, position, count
// out     | out of    | out_valid/ out_stall| popped_value, found, found_position,
//         |           |                     | status, occupancy
//
// each transaction passes through idle and the result state; pop also passes the read-wait state,
// insert and delete copy entries in the copy state, insert then writes its slot in the put state,
// and nothing moves at position 1; one entry moves per cycle over the memory ports.
// find scans with one compare per memory read, stopping at the first match.
// one command is in work at a time; the next is taken while a result waits in the
// output register. the stack storage needs no clearing after reset.
`default_nettype none

module positional_stack_store_top #(
	parameter int DEPTH      = pss_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = pss_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [pss_pkg::CMD_W-1:0]           cmd,
	input  wire logic signed [pss_pkg::VALUE_W-1:0]  item_value,
	input  wire logic [pss_pkg::POS_W-1:0]           position,
	input  wire logic [pss_pkg::POS_W-1:0]           count,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [pss_pkg::VALUE_W-1:0]       popped_value,
	output logic                                     found,
	output logic [pss_pkg::POS_W-1:0]                found_position,
	output logic [pss_pkg::STATUS_W-1:0]             status,
	output logic [pss_pkg::POS_W-1:0]                occupancy
);
	import pss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POPW = 3'd1;
	localparam logic [2:0] S_COPY = 3'd2;
	localparam logic [2:0] S_PUT  = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]            state_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         left_q;
	logic                  is_ins_q;
	logic                  rd_v_s1;
	logic                  out_valid_q;

	logic [AW-1:0]         rptr_q;
	logic [AW-1:0]         wptr_q;
	logic [AW-1:0]         k_q;
	logic [CW-1:0]         spos_q;
	logic [AW-1:0]         wa_s1;
	logic [CW-1:0]         pos_s1;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] rd_data_s1;

	logic signed [VALUE_W-1:0] res_popped_q;
	logic                      res_found_q;
	logic [CW-1:0]             res_fpos_q;
	logic [STATUS_W-1:0]       res_status_q;

	logic signed [VALUE_W-1:0] popped_q;
	logic                      found_q;
	logic [POS_W-1:0]          fpos_q;
	logic [STATUS_W-1:0]       status_q;
	logic [POS_W-1:0]          occ_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic                  accept;
	logic [DATA_WIDTH-1:0] val_in;
	logic [PW-1:0]         fill_w, pos_w, cnt_w;
	logic                  is_full, is_empty, ins_bad, del_bad;
	logic [AW-1:0]         ins_k, del_hi, del_lo;
	logic [CW-1:0]         moves;
	logic                  issue, match, load;
	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	// command decode against the current fill
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign val_in   = DATA_WIDTH'(item_value);
	assign fill_w   = PW'(fill_q);
	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count);
	assign is_full  = (fill_q == FULL_CNT);
	assign is_empty = (fill_q == '0);
	assign ins_bad  = (pos_w == '0) || (pos_w > fill_w + PW'(1));
	assign del_bad  = (pos_w == '0) || (cnt_w == '0) || (pos_w + cnt_w > fill_w + PW'(1));
	assign ins_k    = AW'(fill_w + PW'(1) - pos_w);
	assign del_hi   = AW'(fill_w - pos_w + PW'(1));
	assign del_lo   = AW'(fill_w + PW'(1) - pos_w - cnt_w);
	assign moves    = CW'(pos_w - PW'(1));

	// scan compare and read issue for copy and find
	assign match = (state_q == S_SCAN) && rd_v_s1 && (rd_data_s1 == val_q);
	assign issue = ((state_q == S_COPY) && (left_q != '0))
		|| ((state_q == S_SCAN) && (left_q != '0) && !match);
	assign load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// memory read address
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rptr_q;
		if (issue) begin
			rd_en = 1'b1;
		end else if (state_q == S_IDLE && accept && cmd == CMD_POP && !is_empty) begin
			rd_en   = 1'b1;
			rd_addr = AW'(fill_q - CW'(1));
		end
	end

	// memory write port: copy moves, insert slot, push
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wa_s1;
		wr_data = rd_data_s1;
		if (state_q == S_COPY && rd_v_s1) begin
			wr_en = 1'b1;
		end else if (state_q == S_PUT) begin
			wr_en   = 1'b1;
			wr_addr = k_q;
			wr_data = val_q;
		end else if (state_q == S_IDLE && accept && cmd == CMD_PUSH && !is_full) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[AW-1:0];
			wr_data = val_in;
		end
	end

	// stack storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			left_q      <= '0;
			is_ins_q    <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1     <= issue;
			out_valid_q <= load || (out_valid_q && out_stall);
			if (issue) begin
				left_q <= left_q - CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESP;
						case (cmd)
							CMD_PUSH: begin
								if (!is_full) begin
									fill_q <= fill_q + CW'(1);
								end
							end
							CMD_POP: begin
								if (!is_empty) begin
									fill_q  <= fill_q - CW'(1);
									state_q <= S_POPW;
								end
							end
							CMD_INSERT: begin
								if (!is_full && !ins_bad) begin
									is_ins_q <= 1'b1;
									left_q   <= moves;
									state_q  <= (moves == '0) ? S_PUT : S_COPY;
								end
							end
							CMD_DELETE: begin
								if (!is_empty && !del_bad) begin
									is_ins_q <= 1'b0;
									left_q   <= moves;
									fill_q   <= CW'(fill_w - cnt_w);
									state_q  <= (moves == '0) ? S_RESP : S_COPY;
								end
							end
							CMD_FIND: begin
								if (!is_empty) begin
									left_q  <= fill_q;
									state_q <= S_SCAN;
								end
							end
							CMD_CLEAR: begin
								fill_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_POPW: begin
					state_q <= S_RESP;
				end
				S_COPY: begin
					if (left_q == '0) begin
						state_q <= is_ins_q ? S_PUT : S_RESP;
					end
				end
				S_PUT: begin
					fill_q  <= fill_q + CW'(1);
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (match || (left_q == '0 && !rd_v_s1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pointers, operands and result fields
	always_ff @(posedge clk) begin
		if (issue) begin
			wa_s1  <= wptr_q;
			pos_s1 <= spos_q;
			spos_q <= spos_q + CW'(1);
			if (state_q == S_COPY && !is_ins_q) begin
				rptr_q <= rptr_q + AW'(1);
				wptr_q <= wptr_q + AW'(1);
			end else begin
				rptr_q <= rptr_q - AW'(1);
				wptr_q <= wptr_q - AW'(1);
			end
		end
		if (state_q == S_IDLE && accept) begin
			val_q        <= val_in;
			res_popped_q <= '0;
			res_found_q  <= 1'b0;
			res_fpos_q   <= '0;
			res_status_q <= ST_OK;
			spos_q       <= CW'(1);
			case (cmd)
				CMD_PUSH: begin
					if (is_full) begin
						res_status_q <= ST_FULL;
					end
				end
				CMD_POP: begin
					if (is_empty) begin
						res_status_q <= ST_EMPTY;
					end
				end
				CMD_INSERT: begin
					k_q    <= ins_k;
					rptr_q <= AW'(fill_q - CW'(1));
					wptr_q <= fill_q[AW-1:0];
					if (is_full) begin
						res_status_q <= ST_FULL;
					end else if (ins_bad) begin
						res_status_q <= ST_RANGE;
					end
				end
				CMD_DELETE: begin
					rptr_q <= del_hi;
					wptr_q <= del_lo;
					if (is_empty) begin
						res_status_q <= ST_EMPTY;
					end else if (del_bad) begin
						res_status_q <= ST_RANGE;
					end
				end
				CMD_FIND: begin
					rptr_q <= AW'(fill_q - CW'(1));
					if (is_empty) begin
						res_status_q <= ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_POPW) begin
			res_popped_q <= VALUE_W'($signed(rd_data_s1));
		end
		if (match) begin
			res_found_q <= 1'b1;
			res_fpos_q  <= pos_s1;
		end
		if (load) begin
			popped_q <= res_popped_q;
			found_q  <= res_found_q;
			fpos_q   <= POS_W'(res_fpos_q);
			status_q <= res_status_q;
			occ_q    <= POS_W'(fill_q);
		end
	end

	// result channel outputs
	assign out_valid      = out_valid_q;
	assign popped_value   = popped_q;
	assign found          = found_q;
	assign found_position = fpos_q;
	assign status         = status_q;
	assign occupancy      = occ_q;

	// fill count stays within the store
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above depth");

	// every accepted transaction starts work and leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted transaction did not start");

	// an underflow result always reports an empty store
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_EMPTY |-> occ_q == '0)
		else $error("underflow reported with entries held");

	// a found result carries a nonzero position and ok status
	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP && res_found_q |-> res_fpos_q != '0 && res_status_q == ST_OK)
		else $error("found without position");

	// copy writes never land on the entry being read in the same cycle
	a_copy_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COPY && rd_v_s1 && issue |-> wa_s1 != rptr_q)
		else $error("copy read and write collide");

endmodule

`default_nettype wire
